// ----- src/trd_pkg.sv -----
package trd_pkg;

    // Report framing
    localparam int unsigned REPORT_LEN = 5;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned SYNC_POS   = 7;
    localparam int unsigned TOUCH_POS  = 6;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned REG_W   = 16;
    localparam int unsigned RAW_W   = 15;
    localparam int unsigned PROD_W  = REG_W + RAW_W;
    localparam int unsigned QUOT_W  = PROD_W - 13;
    localparam int unsigned ADDR_W  = 2;

    // Full-scale raw count, 2^14 - 1
    localparam int unsigned FULL_SHIFT = 14;
    localparam logic [FULL_SHIFT:0] RAW_FULL_SCALE = 15'd16383;

    // Register reset values
    localparam logic [REG_W-1:0] SCREEN_W_RST = 16'd4096;
    localparam logic [REG_W-1:0] SCREEN_H_RST = 16'd4096;
    localparam logic [REG_W-1:0] FLIP_RST     = 16'd0;

    // Configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_FLIP_X_ORIGIN = 2'd2,
        CFG_FLIP_Y_ORIGIN = 2'd3
    } t_cfg_reg;

    // Raw coordinate: high byte shifted by 7, low byte ORed in as a full byte
    function automatic logic [RAW_W-1:0] raw_coord(
        input logic [BYTE_W-1:0] lo,
        input logic [BYTE_W-1:0] hi
    );
        raw_coord = {hi, 7'd0} | {7'd0, lo};
    endfunction

    // Floor division by 2^14 - 1 using p = a*16383 + (a + r), applied twice.
    function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
        logic [QUOT_W-2:0]     a;
        logic [FULL_SHIFT-1:0] r;
        logic [QUOT_W-1:0]     b;
        logic [3:0]            c;
        logic [FULL_SHIFT:0]   e;
        logic                  carry;
        a = p[PROD_W-1:FULL_SHIFT];
        r = p[FULL_SHIFT-1:0];
        b = {1'b0, a} + {4'd0, r};
        c = b[QUOT_W-1:FULL_SHIFT];
        e = {11'd0, c} + {1'b0, b[FULL_SHIFT-1:0]};
        carry = (e >= RAW_FULL_SCALE);
        div_full_scale = {1'b0, a} + {14'd0, c} + {17'd0, carry};
    endfunction

    // Scale result cut to 16 bits, then optional flip about the origin
    function automatic logic [REG_W-1:0] flip_axis(
        input logic [QUOT_W-1:0] q,
        input logic [REG_W-1:0]  origin
    );
        flip_axis = (origin != '0) ? origin - q[REG_W-1:0] : q[REG_W-1:0];
    endfunction

endpackage

// ----- src/touch_report_decoder.sv -----
// Touch report decoder. Serial bytes from a touch controller enter on the
// slave stream, one per transaction. Bytes are dropped until one with bit 7
// set arrives; that byte and the next four form a 5-byte report, with no
// further sync check. For each report one transaction leaves on the master
// stream: tuser is the touch flag (bit 6 of the first byte, 1 = touch,
// 0 = release), tdata carries X and Y, each raw coordinate (hi << 7) | lo
// scaled as scale * raw / 16383, cut to 16 bits and, when the flip origin
// register is nonzero, replaced by origin - value (mod 2^16).
// Rate: one byte per clock, with no gaps between reports, while the sink
// keeps up. A result passes through the registered coordinate multipliers
// (stage 1), then through the divide-by-16383 and flip logic feeding the
// output register (stage 2). Both stages move whenever the output register
// is empty or being read, so the slave side only stalls when both stages
// hold a result the sink has not taken. The user must write configuration
// registers only while the block is idle; the block itself does not enforce this.
module touch_report_decoder
    import trd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration write port
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_addr,
    input  logic [REG_W-1:0]    i_cfg_wdata,

    // Byte stream in
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte

    // Report stream out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [2*REG_W-1:0]  m_axis_tdata,   // [15:0] pos_x, [31:16] pos_y
    output logic                m_axis_tuser    // [0] touched
);

    // Configuration registers
    logic [REG_W-1:0] r_screen_w, r_screen_h, r_flip_x, r_flip_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RST;
            r_screen_h <= SCREEN_H_RST;
            r_flip_x   <= FLIP_RST;
            r_flip_y   <= FLIP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_wdata;
                CFG_FLIP_X_ORIGIN: r_flip_x   <= i_cfg_wdata;
                CFG_FLIP_Y_ORIGIN: r_flip_y   <= i_cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Flow control: both stages advance when the output register frees up
    logic r_out_valid, r_prod_valid;
    logic out_free, prod_free, in_acc, last_byte;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign prod_free     = !r_prod_valid || out_free;
    assign s_axis_tready = prod_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Report assembly: index 0 is hunting for the sync byte
    logic [IDX_W-1:0]  r_byte_idx, n_byte_idx;
    logic [BYTE_W-1:0] r_report [REPORT_LEN-1];

    assign last_byte = (r_byte_idx == IDX_W'(REPORT_LEN - 1));

    always_comb begin
        n_byte_idx = r_byte_idx;
        if (in_acc) begin
            priority if (r_byte_idx == '0) begin
                if (s_axis_tdata[SYNC_POS]) n_byte_idx = IDX_W'(1);
            end else if (last_byte) begin
                n_byte_idx = '0;
            end else begin
                n_byte_idx = r_byte_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_byte_idx <= '0;
        else          r_byte_idx <= n_byte_idx;
    end

    // Bytes 0..3 are stored; byte 4 goes straight into the multiplier
    always_ff @(posedge i_clk) begin
        if (in_acc && !last_byte && (r_byte_idx != '0 || s_axis_tdata[SYNC_POS]))
            r_report[r_byte_idx[1:0]] <= s_axis_tdata;
    end

    // Stage 1: registered products scale * raw
    logic [RAW_W-1:0]  raw_x, raw_y;
    logic [PROD_W-1:0] r_prod_x, r_prod_y;
    logic              r_prod_touch;

    assign raw_x = raw_coord(r_report[1], r_report[2]);
    assign raw_y = raw_coord(r_report[3], s_axis_tdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (prod_free) begin
            r_prod_valid <= in_acc && last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && last_byte) begin
            r_prod_x     <= PROD_W'(r_screen_w) * PROD_W'(raw_x);
            r_prod_y     <= PROD_W'(r_screen_h) * PROD_W'(raw_y);
            r_prod_touch <= r_report[0][TOUCH_POS];
        end
    end

    // Stage 2: divide by full scale, flip, into the output register
    logic [REG_W-1:0] r_pos_x, r_pos_y;
    logic             r_touch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_prod_valid) begin
            r_pos_x <= flip_axis(div_full_scale(r_prod_x), r_flip_x);
            r_pos_y <= flip_axis(div_full_scale(r_prod_y), r_flip_y);
            r_touch <= r_prod_touch;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_pos_y, r_pos_x};
    assign m_axis_tuser  = r_touch;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= IDX_W'(REPORT_LEN - 1))
        else $error("byte index out of range");

    a_hunt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_byte_idx == '0 && !s_axis_tdata[SYNC_POS]) |=> (r_byte_idx == '0))
        else $error("non-sync byte opened a report");

    a_report_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last_byte) |=> (r_prod_valid && r_byte_idx == '0))
        else $error("completed report did not reach the product stage");

    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod_valid && !out_free) |=> (r_prod_valid && !$past(s_axis_tready)))
        else $error("product stage lost a result while stalled");
`endif

endmodule

// ----- verif/trd_report_checker.sv -----
`timescale 1ns / 1ps

module trd_report_checker
    import trd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_addr,
    input  logic [REG_W-1:0]    i_cfg_wdata,
    input  logic                i_byte_valid,
    input  logic                i_byte_ready,
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic                i_report_valid,
    input  logic                i_report_ready,
    input  logic [2*REG_W-1:0]  i_report_pos,      // [15:0] pos_x, [31:16] pos_y
    input  logic                i_report_touched,
    output logic [31:0]         o_fail_count,
    output logic [31:0]         o_pending,
    output logic [31:0]         o_report_count,
    output logic                o_hunting
);

    typedef struct packed {
        logic             touched;
        logic [REG_W-1:0] pos_x;
        logic [REG_W-1:0] pos_y;
    } t_touch_report;

    logic [REG_W-1:0]  screen_w, screen_h, origin_x, origin_y;
    logic [IDX_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] frame [REPORT_LEN];
    t_touch_report     expected_reports [$];
    int unsigned       fails, checked;

    initial begin
        o_fail_count   = '0;
        o_pending      = '0;
        o_report_count = '0;
        o_hunting      = 1'b1;
        fails          = 0;
        checked        = 0;
    end

    // (hi << 7) | lo, times the scale, over full scale, low 16 bits, then flip
    function automatic logic [REG_W-1:0] scaled_position(
        input logic [BYTE_W-1:0] lo,
        input logic [BYTE_W-1:0] hi,
        input logic [REG_W-1:0]  scale,
        input logic [REG_W-1:0]  origin
    );
        logic [RAW_W-1:0]  raw;
        longint unsigned   product;
        logic [REG_W-1:0]  pos;
        raw     = {hi, 7'd0} | {7'd0, lo};
        product = 64'(scale) * 64'(raw);
        pos     = REG_W'(product / 64'(RAW_FULL_SCALE));
        if (origin != '0) begin
            pos = origin - pos;
        end
        return pos;
    endfunction

    task automatic take_byte(input logic [BYTE_W-1:0] b);
        t_touch_report rep;
        if (frame_pos == '0) begin
            // hunting: only a byte with the sync bit opens a report
            if (b[SYNC_POS]) begin
                frame[0]  = b;
                frame_pos = IDX_W'(1);
            end
        end else begin
            frame[frame_pos] = b;
            frame_pos        = frame_pos + IDX_W'(1);
            if (frame_pos == IDX_W'(REPORT_LEN)) begin
                frame_pos   = '0;
                rep.touched = frame[0][TOUCH_POS];
                rep.pos_x   = scaled_position(frame[1], frame[2], screen_w, origin_x);
                rep.pos_y   = scaled_position(frame[3], frame[4], screen_h, origin_y);
                expected_reports.push_back(rep);
            end
        end
    endtask

    task automatic check_report();
        t_touch_report want;
        if (expected_reports.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("ERROR: report with nothing expected: touched=%0d x=%0d y=%0d",
                         i_report_touched, i_report_pos[REG_W-1:0],
                         i_report_pos[2*REG_W-1:REG_W]);
            end
            return;
        end
        want = expected_reports.pop_front();
        checked++;
        if (want.touched !== i_report_touched
                || want.pos_x !== i_report_pos[REG_W-1:0]
                || want.pos_y !== i_report_pos[2*REG_W-1:REG_W]) begin
            fails++;
            if (fails <= 10) begin
                $display("ERROR: report %0d: expected touched=%0d x=%0d y=%0d, got %0d %0d %0d",
                         checked, want.touched, want.pos_x, want.pos_y, i_report_touched,
                         i_report_pos[REG_W-1:0], i_report_pos[2*REG_W-1:REG_W]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            screen_w  = SCREEN_W_RST;
            screen_h  = SCREEN_H_RST;
            origin_x  = FLIP_RST;
            origin_y  = FLIP_RST;
            frame_pos = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_SCREEN_WIDTH:  screen_w = i_cfg_wdata;
                    CFG_SCREEN_HEIGHT: screen_h = i_cfg_wdata;
                    CFG_FLIP_X_ORIGIN: origin_x = i_cfg_wdata;
                    CFG_FLIP_Y_ORIGIN: origin_y = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_report_valid && i_report_ready) begin
                check_report();
            end
            if (i_byte_valid && i_byte_ready) begin
                take_byte(i_byte);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= expected_reports.size();
        o_report_count <= checked;
        o_hunting      <= (frame_pos == '0);
    end

endmodule

// ----- verif/tb_touch_report_decoder.sv -----
`timescale 1ns / 1ps

module tb_touch_report_decoder;
    import trd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned DRAIN_CYCLES = 8;     // two pipe stages plus margin
    localparam int unsigned IDLE_PCT     = 16;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr      = '0;
    logic [REG_W-1:0]    cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    logic [2*REG_W-1:0]  m_axis_tdata;      // [15:0] pos_x, [31:16] pos_y
    logic                m_axis_tuser;      // [0] touched

    logic [31:0]         fail_count, pending, report_count;
    logic                hunting;
    logic                idle_on       = 1'b1;   // random gaps on both streams
    int unsigned         cycle_count   = 0;
    int unsigned         bytes_sent    = 0;
    int unsigned         settings_used = 1;

    // Opening sequence with reset registers: noise dropped while hunting,
    // all-zero report, all-ones report (bit 7 of each low byte overlaps bit 0
    // of the high byte in raw bit 7), then one with sync-looking data bytes.
    logic [BYTE_W-1:0] opening [18] = '{
        8'h00, 8'h7F,
        8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hC0, 8'h80, 8'h7F, 8'h81, 8'h00,
        8'h3F
    };

    touch_report_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    trd_report_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_wdata      (cfg_wdata),
        .i_byte_valid     (s_axis_tvalid),
        .i_byte_ready     (s_axis_tready),
        .i_byte           (s_axis_tdata),
        .i_report_valid   (m_axis_tvalid),
        .i_report_ready   (m_axis_tready),
        .i_report_pos     (m_axis_tdata),
        .i_report_touched (m_axis_tuser),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_report_count   (report_count),
        .o_hunting        (hunting)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending);
            $display("FAIL touch_report_decoder");
            $finish;
        end
    end

    // Report sink: random back-pressure while idling is enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // One byte transaction. Sampling right after the edge sees the pre-edge
    // values, since every driver here and in the block updates by NBA.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [REG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // Close any open frame with non-sync filler, then let every report drain
    // so that register writes land while the block is idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (!hunting) begin
            send_byte({1'b0, 7'($urandom)});
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register setting followed by mostly well-formed reports with random
    // content, some noise while hunting and some truncated reports that
    // throw the framing off (no resync, the next sync is just data).
    task automatic run_phase(
        input logic [REG_W-1:0] width,
        input logic [REG_W-1:0] height,
        input logic [REG_W-1:0] flip_x,
        input logic [REG_W-1:0] flip_y,
        input int unsigned      n_bytes,
        input logic             gaps
    );
        int unsigned taken;
        int unsigned pick;
        int unsigned cut;
        taken = 0;
        settle();
        write_reg(CFG_SCREEN_WIDTH, width);
        write_reg(CFG_SCREEN_HEIGHT, height);
        write_reg(CFG_FLIP_X_ORIGIN, flip_x);
        write_reg(CFG_FLIP_Y_ORIGIN, flip_y);
        cfg_we  <= 1'b0;
        idle_on <= gaps;
        settings_used++;
        // full-scale coordinates first: largest product for this setting
        repeat (REPORT_LEN) send_byte(8'hFF);
        taken = REPORT_LEN;
        while (taken < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_byte({1'b1, 7'($urandom)});
                repeat (REPORT_LEN - 1) send_byte(8'($urandom));
                taken += REPORT_LEN;
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) send_byte({1'b0, 7'($urandom)});
            end else begin
                cut = $urandom_range(1, REPORT_LEN - 2);
                send_byte({1'b1, 7'($urandom)});
                repeat (cut) send_byte(8'($urandom));
                taken += cut + 1;
            end
        end
        idle_on <= 1'b1;
    endtask

    function automatic logic [REG_W-1:0] random_origin();
        return ($urandom_range(0, 1) != 0) ? REG_W'($urandom) : '0;
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k]) begin
            send_byte(opening[k]);
        end

        run_phase(REG_W'($urandom), REG_W'($urandom), random_origin(), random_origin(),
                  70, 1'b1);
        // widest scale: products overflow 16 bits before truncation
        run_phase(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 50, 1'b1);
        // zero scale, plain and flipped
        run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, 40, 1'b1);
        run_phase(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 40, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 50, 1'b1);
        // long stretch at full rate on both streams
        run_phase(REG_W'($urandom), REG_W'($urandom), random_origin(), random_origin(),
                  100, 1'b0);
        run_phase(16'h0001, REG_W'($urandom), 16'h8000, random_origin(), 40, 1'b1);
        run_phase(REG_W'($urandom), REG_W'($urandom), random_origin(), random_origin(),
                  60, 1'b1);

        settle();
        $display("Sent %0d bytes over %0d register settings, checked %0d reports",
                 bytes_sent, settings_used, report_count);
        $display("Covered sync hunting, misframed reports, zero and full scale, flips.");
        if (fail_count == 0) begin
            $display("PASS touch_report_decoder");
        end else begin
            $display("%0d mismatching reports", fail_count);
            $display("FAIL touch_report_decoder");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/trd_pkg.sv
src/touch_report_decoder.sv
verif/trd_report_checker.sv
verif/tb_touch_report_decoder.sv
